// ===== sv/lsbx_pkg.sv =====
// ---------------------------------------------------------------------------
// lsbx_pkg: shared types and constants of the LSB audio payload extractor
// Transfer structs of both channels, frame layout and register map.
// ---------------------------------------------------------------------------
package lsbx_pkg;

   localparam int NAME_BYTES   = 32;
   localparam int LENGTH_BYTES = 4;

   // samples taken by length, type and name bytes together
   localparam int HEADER_BITS = (LENGTH_BYTES + 1 + NAME_BYTES) * 8;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // register index, taken from paddr[2]
   localparam logic REG_TOTAL_SAMPLES = 1'b0;

   typedef struct packed {
      logic signed [15:0] sample_value;
      logic               start_req;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic        section;
      logic [4:0]  name_index;
      logic [31:0] payload_length;
      logic        is_file;
      logic        length_error;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// ===== sv/lsbx_parser.sv =====
// ---------------------------------------------------------------------------
// lsbx_parser: frame parser
// Shifts sample LSBs into bytes and walks length, type, name and payload
// sections; gives at most one result per accepted sample.
// ---------------------------------------------------------------------------
module lsbx_parser
   import lsbx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        sample_accept,
   input  req_type     sample,
   input  logic [31:0] total_samples,
   output result_type  result
);

   localparam logic [2:0] PH_LEN  = 3'd0;
   localparam logic [2:0] PH_TYPE = 3'd1;
   localparam logic [2:0] PH_NAME = 3'd2;
   localparam logic [2:0] PH_PAY  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   logic [2:0]  phase_ff,    phase_in;
   logic [2:0]  bit_cnt_ff,  bit_cnt_in;
   logic [7:0]  shift_ff,    shift_in;
   logic [31:0] count_ff,    count_in;
   logic [31:0] length_ff,   length_in;
   logic        type_ff,     type_in;

   logic [2:0]  phase_base;
   logic [2:0]  bit_cnt_base;
   logic [7:0]  shift_base;
   logic [31:0] count_base;
   logic [31:0] length_base;
   logic        type_base;
   logic [7:0]  byte_now;
   logic [2:0]  bit_cnt_next;
   logic [31:0] count_inc;
   logic [35:0] need;
   logic        over;

   always_comb begin
      if (sample.start_req) begin
         phase_base   = PH_LEN;
         bit_cnt_base = '0;
         shift_base   = '0;
         count_base   = '0;
         length_base  = '0;
         type_base    = 1'b0;
      end else begin
         phase_base   = phase_ff;
         bit_cnt_base = bit_cnt_ff;
         shift_base   = shift_ff;
         count_base   = count_ff;
         length_base  = length_ff;
         type_base    = type_ff;
      end

      byte_now     = {shift_base[6:0], sample.sample_value[0]};
      bit_cnt_next = bit_cnt_base + 3'd1;
      count_inc    = count_base + 32'd1;
      need         = {1'b0, length_base, 3'b000} + 36'(HEADER_BITS);
      over         = need > {4'b0000, total_samples};

      phase_in   = phase_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      type_in    = type_ff;

      result.valid               = 1'b0;
      result.data.byte_value     = byte_now;
      result.data.section        = 1'b0;
      result.data.name_index     = count_base[4:0];
      result.data.payload_length = length_base;
      result.data.is_file        = type_base;
      result.data.length_error   = 1'b0;
      result.data.last           = 1'b0;

      if (sample_accept) begin
         phase_in   = phase_base;
         bit_cnt_in = bit_cnt_base;
         shift_in   = shift_base;
         count_in   = count_base;
         length_in  = length_base;
         type_in    = type_base;

         if (phase_base == PH_LEN || phase_base == PH_TYPE ||
             phase_base == PH_NAME || phase_base == PH_PAY) begin
            bit_cnt_in = bit_cnt_next;
            if (bit_cnt_next != 3'd0) begin
               shift_in = byte_now;
            end else begin
               shift_in = '0;
               case (phase_base)
                  PH_LEN: begin
                     length_in = {length_base[23:0], byte_now};
                     count_in  = count_inc;
                     if (count_inc >= 32'(LENGTH_BYTES)) begin
                        count_in = '0;
                        phase_in = PH_TYPE;
                     end
                  end
                  PH_TYPE: begin
                     type_in  = byte_now != 8'd0;
                     count_in = '0;
                     phase_in = PH_NAME;
                  end
                  PH_NAME: begin
                     result.valid = 1'b1;
                     result.data.is_file = type_base;
                     count_in = count_inc;
                     if (count_inc >= 32'(NAME_BYTES)) begin
                        count_in = '0;
                        if (over) begin
                           phase_in = PH_DONE;
                           result.data.length_error = 1'b1;
                           result.data.last         = 1'b1;
                        end else if (length_base == 32'd0) begin
                           phase_in = PH_DONE;
                           result.data.last = 1'b1;
                        end else begin
                           phase_in = PH_PAY;
                        end
                     end
                  end
                  default: begin
                     result.valid           = 1'b1;
                     result.data.section    = 1'b1;
                     result.data.name_index = '0;
                     count_in = count_inc;
                     if (count_inc >= length_base) begin
                        phase_in = PH_DONE;
                        result.data.last = 1'b1;
                     end
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEN;
         bit_cnt_ff <= '0;
         shift_ff   <= '0;
         count_ff   <= '0;
         length_ff  <= '0;
         type_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         type_ff    <= type_in;
      end
   end

endmodule

// ===== sv/lsb_audio_payload_extractor.sv =====
// ---------------------------------------------------------------------------
// A result appears on rsp in the cycle after the sample that completes its
// byte is transferred. Throughput: one sample per cycle, limited only by
// the single output register and its stall. Synchronous reset clears the
// parser to the length section, total_samples to zero and rsp_valid.
// ---------------------------------------------------------------------------
// lsb_audio_payload_extractor: LSB audio payload extractor
// Rebuilds bytes from sample LSBs, parses the frame header and returns
// name and payload bytes with a capacity check.
// ---------------------------------------------------------------------------
module lsb_audio_payload_extractor
   import lsbx_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [31:0] total_ff,     total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff,  rsp_data_in;
   logic        req_accept;
   result_type  result;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TOTAL_SAMPLES) ? total_ff : '0;

   always_comb begin
      total_in = total_ff;
      if (csr_psel && csr_penable && csr_pwrite &&
          csr_paddr[2] == REG_TOTAL_SAMPLES) begin
         total_in = csr_pwdata;
      end
   end

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   lsbx_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .sample_accept (req_accept),
      .sample        (req_data),
      .total_samples (total_ff),
      .result        (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
